// File: sv/stack_queue_list_pool_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the list pool block
// Clocked concurrent property wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef STACK_QUEUE_LIST_POOL_MACROS_SVH
`define STACK_QUEUE_LIST_POOL_MACROS_SVH

`ifndef SYNTHESIS
`define SQLP_ASSERT_NOW(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define SQLP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SQLP_ASSERT_NOW(name, expr)
`define SQLP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: sv/sqlp_pkg.sv
// ----------------------------------------------------------------------------
// List pool package
// Request codes, status codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package sqlp_pkg;

  localparam int OP_W  = 2;
  localparam int ID_W  = 4;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EXISTS = 3'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and start the memory reads
    logic commit;   // update state and load the result register
  } sqlp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy; // result register is full and held by the consumer
  } sqlp_stat_t;

endpackage

// File: sv/sqlp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sqlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/sqlp_ctrl.sv
// ----------------------------------------------------------------------------
// List pool controller
// Two-state sequencer: capture a request, then commit it to the datapath.
// ----------------------------------------------------------------------------
module sqlp_ctrl
  import sqlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sqlp_stat_t stat,
  output sqlp_cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.commit  = (state_r == S_EXEC) && !stat.out_busy;
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!stat.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/sqlp_dp.sv
// ----------------------------------------------------------------------------
// List pool datapath
// List tables, free list, node memories and the result register.
// ----------------------------------------------------------------------------
module sqlp_dp
  import sqlp_pkg::*;
#(
  parameter int NUM_LISTS  = 16,
  parameter int POOL_NODES = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sqlp_cmd_t               cmd,
  output sqlp_stat_t              stat,
  input  logic [OP_W-1:0]         in_op,
  input  logic [ID_W-1:0]         in_list_id,
  input  logic                    in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_popped_value
);

  // Only sixteen list indexes are reachable through the request field.
  localparam int LISTS = (NUM_LISTS < 16) ? NUM_LISTS : 16;
  localparam int LIW   = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int AW    = $clog2(POOL_NODES);
  localparam int CW    = $clog2(POOL_NODES + 1);

  logic [LISTS-1:0] used_r;
  logic [LISTS-1:0] stack_r;
  logic [AW-1:0]    head_r  [LISTS];
  logic [AW-1:0]    tail_r  [LISTS];
  logic [CW-1:0]    count_r [LISTS];

  logic [AW-1:0] free_head_r;
  logic [CW-1:0] free_count_r;
  logic [CW-1:0] hwm_r;  // nodes below this mark have been handed out before

  logic [OP_W-1:0]  op_r;
  logic [ID_W-1:0]  id_r;
  logic             kind_r;
  logic [VAL_W-1:0] val_r;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [VAL_W-1:0] out_popped_r;

  logic [LIW-1:0]        li_in;
  logic [LIW-1:0]        li;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         link_rd;
  logic [DATA_WIDTH-1:0] value_rd;

  logic                  present;
  logic                  in_range;
  logic                  do_create;
  logic                  do_push;
  logic                  do_pop;
  logic [ST_W-1:0]       status_c;
  logic                  fresh;
  logic [AW-1:0]         seq_next;
  logic [AW-1:0]         free_next;
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [AW-1:0]         link_wdata;

  assign li_in = in_list_id[LIW-1:0];
  assign li    = id_r[LIW-1:0];

  // Pop reads the head node; push reads the link of the free-list head.
  assign rd_addr = (in_op == OP_POP) ? head_r[li_in] : free_head_r;

  assign in_range = ({1'b0, id_r} < 5'(LISTS));
  assign present  = in_range && used_r[li];

  // A node that was never handed out has no link written yet; its successor
  // on the free list is taken to be the next node in index order.
  assign fresh    = (CW'(free_head_r) == hwm_r);
  assign seq_next = (free_head_r == AW'(POOL_NODES - 1)) ? '0 : free_head_r + 1'b1;
  assign free_next = fresh ? seq_next : link_rd;

  always_comb begin
    status_c  = ST_OK;
    do_create = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    case (op_r)
      OP_CREATE: begin
        if (!in_range) begin
          status_c = ST_ABSENT;
        end else if (present) begin
          status_c = ST_EXISTS;
        end else begin
          do_create = 1'b1;
        end
      end
      OP_PUSH: begin
        if (!present) begin
          status_c = ST_ABSENT;
        end else if (free_count_r == '0) begin
          status_c = ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      OP_POP: begin
        if (!present) begin
          status_c = ST_ABSENT;
        end else if (count_r[li] == '0) begin
          status_c = ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = free_head_r;
    link_wdata = head_r[li];
    if (cmd.commit && do_push && (count_r[li] != '0)) begin
      link_we = 1'b1;
      if (stack_r[li]) begin
        link_waddr = free_head_r;
        link_wdata = head_r[li];
      end else begin
        link_waddr = tail_r[li];
        link_wdata = free_head_r;
      end
    end else if (cmd.commit && do_pop) begin
      link_we    = 1'b1;
      link_waddr = head_r[li];
      link_wdata = free_head_r;
    end
  end

  sqlp_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  sqlp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_NODES)) u_value_ram (
    .clk   (clk),
    .we    (cmd.commit && do_push),
    .waddr (free_head_r),
    .wdata (DATA_WIDTH'(val_r)),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (value_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      id_r   <= in_list_id;
      kind_r <= in_kind;
      val_r  <= unsigned'(in_value);
    end
    if (cmd.commit && do_push) begin
      if (count_r[li] == '0) begin
        head_r[li] <= free_head_r;
        tail_r[li] <= free_head_r;
      end else if (stack_r[li]) begin
        head_r[li] <= free_head_r;
      end else begin
        tail_r[li] <= free_head_r;
      end
    end
    if (cmd.commit && do_pop) begin
      head_r[li] <= link_rd;
    end
    if (cmd.commit) begin
      out_status_r <= status_c;
      out_popped_r <= do_pop ? VAL_W'(value_rd) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      stack_r      <= '0;
      free_head_r  <= '0;
      free_count_r <= CW'(POOL_NODES);
      hwm_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit && do_create) begin
        used_r[li]  <= 1'b1;
        stack_r[li] <= kind_r;
        count_r[li] <= '0;
      end
      if (cmd.commit && do_push) begin
        count_r[li]  <= count_r[li] + 1'b1;
        free_head_r  <= free_next;
        free_count_r <= free_count_r - 1'b1;
        if (fresh) begin
          hwm_r <= hwm_r + 1'b1;
        end
      end
      if (cmd.commit && do_pop) begin
        count_r[li]  <= count_r[li] - 1'b1;
        free_head_r  <= head_r[li];
        free_count_r <= free_count_r + 1'b1;
      end
    end
  end

  assign stat.out_busy    = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = signed'(out_popped_r);

endmodule

// File: sv/stack_queue_list_pool.sv
// ----------------------------------------------------------------------------
// Stack and queue list pool
// Numbered stacks and queues sharing one linked node pool with a free list.
// ----------------------------------------------------------------------------
// The block keeps up to sixteen numbered lists, each created once as a stack
// (kind 1) or a queue (kind 0). All entries live in one pool of POOL_NODES
// nodes; a push takes the node at the head of the free list and a pop hands
// the head node of the list back to it. Every request yields exactly one
// result carrying a status and, for a successful pop, the removed value.
// In the capture state a request is registered and the node memories are
// read; the execute state waits while the consumer holds the result register,
// then updates the list tables and memories and loads the result register,
// after which the next request is taken, even while that result waits. The
// node memories need no clearing pass after reset: a mark of the nodes
// handed out so far stands in for the reset chaining of the free list, so
// the block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
`include "stack_queue_list_pool_macros.svh"

module stack_queue_list_pool
  import sqlp_pkg::*;
#(
  parameter int NUM_LISTS  = 16,
  parameter int POOL_NODES = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic [ID_W-1:0]         in_list_id,
  input  logic                    in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_popped_value
);

  sqlp_cmd_t  cmd;
  sqlp_stat_t stat;

  // The controller sequences each request; the datapath holds the list state.
  sqlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqlp_dp #(
    .NUM_LISTS  (NUM_LISTS),
    .POOL_NODES (POOL_NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_list_id       (in_list_id),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value)
  );

  // A request is held off in the cycle after it is taken.
  `SQLP_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  // Only a successful pop returns a nonzero value.
  `SQLP_ASSERT_NOW(a_pop_value_zero, !out_valid || out_status == ST_OK || out_popped_value == '0)
  // Status codes stay within the defined set.
  `SQLP_ASSERT_NOW(a_status_range, !out_valid || out_status <= ST_FULL)

endmodule
